// ===== design/rwre_pkg.sv =====
// Shared types and constants of the renewal window R estimator.
package rwre_pkg;

   localparam int WEIGHT_REGS = 7;
   localparam int WEIGHT_W    = 17;
   localparam int WIDX_W      = 3;
   localparam int EXTRA_W     = 5;
   localparam int COUNT_W     = 16;
   localparam int LAMBDA_W    = 35;
   localparam int INC_W       = 21;
   localparam int LSUM_W      = 40;
   localparam int LEN_W       = 6;
   localparam int DAYS_W      = 6;
   localparam int NUM_W       = 24;
   localparam int DEN_W       = 43;
   localparam int QUO_W       = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 17'd65536;
   localparam logic [DAYS_W-1:0]   DAYS_CAP       = 6'd33;
   localparam logic [DEN_W-1:0]    DEN_BIAS       = 43'd65536;
   localparam logic [WIDX_W-1:0]   REG_WINDOW_EXTRA = 3'd7;
   localparam logic [EXTRA_W-1:0]  EXTRA_RESET    = 5'd6;

   typedef struct packed {
      logic [WEIGHT_REGS-1:0][WEIGHT_W-1:0] weight;
      logic [EXTRA_W-1:0]                   window_extra;
   } rwre_cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [LAMBDA_W-1:0] lambda;
   } rwre_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rwre_div_stat_type;

endpackage

// ===== design/renewal_window_r_estimator_top.sv =====
// Top level of the renewal window R estimator: sequencer, infectivity MAC, window sums.
// Flow: an accepted request runs the MAC over TAPS taps and writes the day; once the window
//   is warm it reads back len = min(window_extra + 1, WINDOW_DEPTH) days and divides, and
//   a saturated result skips the 32 divide steps.
// Requests: one day at a time; a new one is taken only in idle, so a stalled result holds it off.
// Reset: synchronous, active high; clears the day counter, write pointer, history and handshake
//   state; the window memory is never read before it is written, so it needs no clearing pass.
module renewal_window_r_estimator_top #(
   parameter int TAPS         = 7,
   parameter int WINDOW_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // [15:0] day_count
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [95:0]                       rsp_tdata,   // [31:0] r_estimate,
                                                          // [52:32] window_incidence,
                                                          // [92:53] window_infectivity,
                                                          // [95:93] zero
   output logic [0:0]                        rsp_tuser,   // [0] saturated
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rwre_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rwre_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rwre_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import rwre_pkg::*;

   localparam int ADDR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int LEN_CAP   = (WINDOW_DEPTH < 32) ? WINDOW_DEPTH : 32;
   localparam logic [LEN_W-1:0]  LEN_CAP_V = LEN_W'(LEN_CAP);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);
   localparam logic [WIDX_W-1:0] LAST_TAP  = WIDX_W'(TAPS - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MAC   = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_PREP  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   rwre_cfg_type       cfg;
   rwre_div_stat_type  div_stat;
   rwre_entry_type     wr_entry;
   rwre_entry_type     rd_entry;

   logic [2:0]            state_ff, state_in;
   logic [WIDX_W-1:0]     tap_ff, tap_in;
   logic [LAMBDA_W-1:0]   acc_ff, acc_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    recent_ff [TAPS];
   logic [DAYS_W-1:0]     days_ff, days_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      issue_ff, issue_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [ADDR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [INC_W-1:0]      inc_ff, inc_in;
   logic [LSUM_W-1:0]     lsum_ff, lsum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [95:0]           rsp_data_ff;
   logic                  rsp_sat_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic                  div_start;
   logic                  shift_recent;
   logic [WEIGHT_W-1:0]   weight_sel;
   logic [WEIGHT_W-1:0]   weight_clamp;
   logic [32:0]           product;
   logic [LEN_W-1:0]      extra_plus;
   logic [DAYS_W-1:0]     days_next;
   logic [INC_W:0]        inc_plus;
   logic [NUM_W-1:0]      num_hi;
   logic [DEN_W-1:0]      den;
   logic [QUO_W-1:0]      quotient;
   logic                  quo_sat;

   rwre_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rwre_window_mem #(
      .DEPTH  (WINDOW_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_window_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_entry),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_entry)
   );

   rwre_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .num_hi    (num_hi),
      .den       (den),
      .quotient  (quotient),
      .saturated (quo_sat),
      .stat      (div_stat)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;

   // one MAC tap per cycle; a weight above one acts as one
   assign weight_sel   = cfg.weight[tap_ff];
   assign weight_clamp = (weight_sel > WEIGHT_ONE) ? WEIGHT_ONE : weight_sel;
   assign product      = 33'(weight_clamp) * 33'(recent_ff[tap_ff[TAP_IDX_W-1:0]]);

   // window length and warm-up test
   assign extra_plus = LEN_W'(cfg.window_extra) + LEN_W'(1);
   assign days_next  = (days_ff < DAYS_CAP) ? days_ff + DAYS_W'(1) : days_ff;

   assign wr_entry.count  = count_ff;
   assign wr_entry.lambda = acc_ff;
   assign mem_wr_en       = (state_ff == S_WRITE);
   assign mem_rd_en       = (state_ff == S_SUM) && (issue_ff < len_ff);
   assign shift_recent    = (state_ff == S_WRITE);

   // divider operands: (inc + 1) * 5 and lam * 5 + 2^16
   assign inc_plus  = {1'b0, inc_ff} + (INC_W + 1)'(1);
   assign num_hi    = (NUM_W'(inc_plus) << 2) + NUM_W'(inc_plus);
   assign den       = (DEN_W'(lsum_ff) << 2) + DEN_W'(lsum_ff) + DEN_BIAS;
   assign div_start = (state_ff == S_PREP);

   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      days_in    = days_ff;
      len_in     = len_ff;
      issue_in   = issue_ff;
      rd_pend_in = 1'b0;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      inc_in     = inc_ff;
      lsum_in    = lsum_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               count_in = req_tdata;
               tap_in   = '0;
               acc_in   = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            acc_in = acc_ff + LAMBDA_W'(product);
            tap_in = tap_ff + WIDX_W'(1);
            if (tap_ff == LAST_TAP) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // store the newest day, then walk back over the window
            len_in    = (extra_plus > LEN_CAP_V) ? LEN_CAP_V : extra_plus;
            days_in   = days_next;
            rd_ptr_in = wr_ptr_ff;
            wr_ptr_in = (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + ADDR_W'(1);
            issue_in  = '0;
            inc_in    = '0;
            lsum_in   = '0;
            if (days_next > len_in) begin
               state_in = S_SUM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SUM: begin
            if (mem_rd_en) begin
               issue_in   = issue_ff + LEN_W'(1);
               rd_ptr_in  = (rd_ptr_ff == '0) ? LAST_ADDR : rd_ptr_ff - ADDR_W'(1);
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               inc_in  = inc_ff + INC_W'(rd_entry.count);
               lsum_in = lsum_ff + LSUM_W'(rd_entry.lambda);
            end
            if (!mem_rd_en && !rd_pend_ff) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         days_ff      <= '0;
         wr_ptr_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TAPS; i++) begin
            recent_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         days_ff      <= days_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         // advance the count history once the day's infectivity is formed
         if (shift_recent) begin
            for (int i = TAPS - 1; i > 0; i--) begin
               recent_ff[i] <= recent_ff[i - 1];
            end
            recent_ff[0] <= count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      tap_ff    <= tap_in;
      acc_ff    <= acc_in;
      count_ff  <= count_in;
      len_ff    <= len_in;
      issue_ff  <= issue_in;
      rd_ptr_ff <= rd_ptr_in;
      inc_ff    <= inc_in;
      lsum_ff   <= lsum_in;
      if (rsp_load) begin
         rsp_data_ff <= {3'b000, lsum_ff, inc_ff, quotient};
         rsp_sat_ff  <= quo_sat;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

   // a result is only formed once the whole window holds stored days
   a_emit_after_warmup: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (days_ff > len_ff))
      else $error("result loaded before the window is filled");

   // the read loop never issues past the window length
   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |-> (issue_ff <= len_ff))
      else $error("window read count ran past the window length");

   // the divider only runs while the sequencer waits for it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || div_stat.done) |-> (state_ff == S_DIV))
      else $error("divider active outside the divide state");

   // an accepted request always starts the MAC
   a_accept_to_mac: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_MAC))
      else $error("accepted request did not start the MAC");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff) && rsp_valid_ff)
      else $error("stalled result changed");

endmodule

// ===== design/rwre_csr.sv =====
// Configuration register file behind the APB-style port.
module rwre_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rwre_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rwre_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rwre_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output rwre_pkg::rwre_cfg_type            cfg
);
   import rwre_pkg::*;

   rwre_cfg_type        cfg_ff;
   logic [WIDX_W-1:0]   reg_idx;
   logic                wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i < WEIGHT_REGS; i++) begin
            cfg_ff.weight[i] <= '0;
         end
         cfg_ff.weight[0]    <= WEIGHT_ONE;
         cfg_ff.window_extra <= EXTRA_RESET;
      end else if (wr_en) begin
         if (reg_idx == REG_WINDOW_EXTRA) begin
            cfg_ff.window_extra <= csr_pwdata[EXTRA_W-1:0];
         end else begin
            cfg_ff.weight[reg_idx] <= csr_pwdata[WEIGHT_W-1:0];
         end
      end
   end

   always_comb begin
      if (reg_idx == REG_WINDOW_EXTRA) begin
         csr_prdata = CSR_DATA_W'(cfg_ff.window_extra);
      end else begin
         csr_prdata = CSR_DATA_W'(cfg_ff.weight[reg_idx]);
      end
   end

endmodule

// ===== design/rwre_window_mem.sv =====
// Window store: one write port, one registered read port.
module rwre_window_mem #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  rwre_pkg::rwre_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output rwre_pkg::rwre_entry_type rd_data
);
   import rwre_pkg::*;

   rwre_entry_type mem [DEPTH];
   rwre_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rwre_divider.sv =====
// Bit-serial restoring divider for the Q16.16 estimate, with saturation.
module rwre_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rwre_pkg::NUM_W-1:0]      num_hi,
   input  logic [rwre_pkg::DEN_W-1:0]      den,
   output logic [rwre_pkg::QUO_W-1:0]      quotient,
   output logic                            saturated,
   output rwre_pkg::rwre_div_stat_type     stat
);
   import rwre_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic               sat_ff, sat_in;
   logic [DEN_W:0]     rem_shift;
   logic [DEN_W:0]     rem_diff;
   logic [DEN_W-1:0]   num_ext;

   assign num_ext   = DEN_W'(num_hi);
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      if (start) begin
         den_in = den;
         cnt_in = '0;
         if (num_ext >= den) begin
            // quotient would need more than 32 bits
            quo_in  = '1;
            sat_in  = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = num_ext;
            quo_in  = '0;
            sat_in  = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_diff[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign quotient  = quo_ff;
   assign saturated = sat_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== tb/renewal_window_r_estimator_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the renewal window R estimator: directed and random days.
module renewal_window_r_estimator_top_tb;
   import rwre_pkg::*;

   localparam int TAPS          = 7;
   localparam int WINDOW_DEPTH  = 32;
   // Quiet time before a register write, rounded up from the longest day.
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int PHASE_DAYS    = 125;
   localparam int PRINT_LIMIT   = 50;

   // One expected result, in the order the result channel carries its fields.
   typedef struct packed {
      logic [QUO_W-1:0]  r;
      logic [INC_W-1:0]  inc;
      logic [LSUM_W-1:0] lam;
      logic              sat;
   } estimate_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;    // [15:0] day_count
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [95:0]           rsp_tdata;    // [31:0] r_estimate, [52:32] window_incidence,
                                        // [92:53] window_infectivity, [95:93] zero
   logic [0:0]            rsp_tuser;    // [0] saturated
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor copy of the registers and the day history.
   logic [WEIGHT_W-1:0]   model_weight [WEIGHT_REGS];
   logic [EXTRA_W-1:0]    model_extra;
   logic [COUNT_W-1:0]    lag_counts   [TAPS];
   logic [COUNT_W-1:0]    win_counts   [WINDOW_DEPTH];
   logic [LAMBDA_W-1:0]   win_lambdas  [WINDOW_DEPTH];
   int unsigned           days_seen;
   estimate_type          pending_estimates [$];

   int                    send_idle_pct;
   int                    rsp_stall_pct;
   int                    error_count;
   int                    days_sent;
   int                    estimates_checked;
   int                    saturated_seen;
   int                    settings_used;
   longint                cycle_count;

   renewal_window_r_estimator_top #(
      .TAPS         (TAPS),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Put the predictor in its after-reset state: unit weight one day back, 7-day window.
   function automatic void clear_model();
      int j;
      for (j = 0; j < WEIGHT_REGS; j++) model_weight[j] = '0;
      model_weight[0] = WEIGHT_ONE;
      model_extra = EXTRA_RESET;
      for (j = 0; j < TAPS; j++) lag_counts[j] = '0;
      for (j = 0; j < WINDOW_DEPTH; j++) begin
         win_counts[j]  = '0;
         win_lambdas[j] = '0;
      end
      days_seen = 0;
   endfunction

   // Advance the history by one day and queue the estimate that day produces, if any.
   function automatic void predict_day_estimate(input logic [COUNT_W-1:0] count);
      logic [63:0] infect;
      logic [63:0] w;
      logic [63:0] inc;
      logic [63:0] lsum;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quo;
      int unsigned len;
      int          j;
      estimate_type est;
      // Infectivity uses the counts before today's arrives; clip weights at one.
      infect = '0;
      for (j = 0; j < TAPS; j++) begin
         w = (model_weight[j] > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(model_weight[j]);
         infect = infect + w * 64'(lag_counts[j]);
      end
      infect = infect & ((64'd1 << LAMBDA_W) - 64'd1);
      for (j = TAPS - 1; j > 0; j--) lag_counts[j] = lag_counts[j - 1];
      lag_counts[0] = count;
      for (j = WINDOW_DEPTH - 1; j > 0; j--) begin
         win_counts[j]  = win_counts[j - 1];
         win_lambdas[j] = win_lambdas[j - 1];
      end
      win_counts[0]  = count;
      win_lambdas[0] = infect[LAMBDA_W-1:0];
      if (days_seen < DAYS_CAP) days_seen++;
      // Sum afresh over the newest len days, so a new window applies at once.
      len = int'(model_extra) + 1;
      if (len > WINDOW_DEPTH) len = WINDOW_DEPTH;
      inc  = '0;
      lsum = '0;
      for (j = 0; j < len; j++) begin
         inc  = inc + 64'(win_counts[j]);
         lsum = lsum + 64'(win_lambdas[j]);
      end
      // Hold back results until the window plus one day has arrived.
      if (days_seen < len + 1) return;
      est.inc = inc[INC_W-1:0];
      est.lam = lsum[LSUM_W-1:0];
      num = ((64'(est.inc) + 64'd1) * 64'd5) << 32;
      den = 64'(est.lam) * 64'd5 + 64'(DEN_BIAS);
      quo = num / den;
      est.sat = (quo > 64'hFFFF_FFFF);
      est.r   = est.sat ? '1 : quo[QUO_W-1:0];
      pending_estimates.push_back(est);
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                  $realtime, estimates_checked, field, got, want);
      error_count++;
   endtask

   // Write one register in a setup and an access cycle, then mirror it in the predictor.
   task automatic write_register(input int index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (index < WEIGHT_REGS)
         model_weight[index] = value[WEIGHT_W-1:0];
      else if (index == int'(REG_WINDOW_EXTRA))
         model_extra = value[EXTRA_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drop the request, wait out every pending result, then the longest no-result day.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one day count; hold_for_drain first lets every pending result come back.
   task automatic send_day(input logic [COUNT_W-1:0] count, input logic hold_for_drain);
      @(negedge clock);
      if (hold_for_drain) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while (pending_estimates.size() != 0);
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      // Keep valid high straight into the next request when no gap is drawn.
      req_tvalid <= 1'b1;
      req_tdata  <= count;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_day_estimate(count);
      days_sent++;
   endtask

   function automatic logic [COUNT_W-1:0] random_count();
      logic [COUNT_W-1:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c = COUNT_W'($urandom);
         4, 5:       c = COUNT_W'($urandom_range(0, 63));
         6:          c = '1;
         7:          c = '0;
         8:          c = COUNT_W'($urandom_range(60000, 65535));
         default:    c = COUNT_W'(1) << $urandom_range(0, COUNT_W - 1);
      endcase
      return c;
   endfunction

   // Write all seven weights and the window; upper data bits carry junk the block must drop.
   task automatic load_setting(input logic [WEIGHT_W-1:0] weights [WEIGHT_REGS],
                               input logic [EXTRA_W-1:0] extra);
      logic [CSR_DATA_W-1:0] data;
      int                    j;
      wait_idle();
      for (j = 0; j < WEIGHT_REGS; j++) begin
         data = $urandom;
         data[WEIGHT_W-1:0] = weights[j];
         write_register(j, data);
      end
      data = $urandom;
      data[EXTRA_W-1:0] = extra;
      write_register(int'(REG_WINDOW_EXTRA), data);
      settings_used++;
   endtask

   // Reset defaults: no results through the 7-day warm-up, then one per day.
   task automatic test_warmup_defaults();
      logic [COUNT_W-1:0] days [10];
      int                 j;
      days = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'h7FFF,
               16'h5555, 16'hAAAA, 16'hFFFF, 16'd0, 16'd12};
      for (j = 0; j < 10; j++) send_day(days[j], 1'b0);
   endtask

   // Weights from zero to above one on a one-day window, with full counts in every tap.
   task automatic test_weight_extremes();
      logic [WEIGHT_W-1:0] weights [WEIGHT_REGS];
      int                  j;
      weights = '{17'h1FFFF, WEIGHT_ONE, 17'd0, 17'd65537, 17'd1, 17'h1FFFF, 17'd65535};
      load_setting(weights, '0);
      for (j = 0; j < 7; j++) send_day('1, 1'b0);
      send_day('0, 1'b0);
      send_day(16'd1, 1'b0);
   endtask

   // Zero infectivity: walk the estimate across the saturation edge.
   task automatic test_saturation_edge();
      logic [WEIGHT_W-1:0] weights [WEIGHT_REGS];
      int                  j;
      for (j = 0; j < WEIGHT_REGS; j++) weights[j] = '0;
      load_setting(weights, '0);
      send_day('1, 1'b0);          // clip
      send_day('0, 1'b0);          // R = 5 exactly
      send_day(16'd13106, 1'b0);   // last count below the clip
      send_day(16'd13107, 1'b0);   // first count that clips
   endtask

   // Random days under four idling modes and three settings per mode.
   task automatic test_random_traffic();
      logic [WEIGHT_W-1:0] weights [WEIGHT_REGS];
      logic [EXTRA_W-1:0]  extra;
      int                  mode;
      int                  slot;
      int                  n;
      int                  j;
      logic                hold;
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 86; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         for (slot = 0; slot < 3; slot++) begin
            // First mode opens with the extremes: widest window at top weights, then the
            // narrowest at zero weights. Everything else is drawn.
            for (j = 0; j < WEIGHT_REGS; j++) begin
               if (mode == 0 && slot == 0)
                  weights[j] = '1;
               else if (mode == 0 && slot == 1)
                  weights[j] = '0;
               else begin
                  case ($urandom_range(0, 4))
                     0:       weights[j] = '0;
                     1:       weights[j] = WEIGHT_ONE;
                     2:       weights[j] = WEIGHT_W'($urandom_range(65537, 131071));
                     default: weights[j] = WEIGHT_W'($urandom_range(0, 65535));
                  endcase
               end
            end
            if (mode == 0 && slot == 0)
               extra = '1;
            else if (mode == 0 && slot == 1)
               extra = '0;
            else
               extra = EXTRA_W'($urandom_range(0, 31));
            load_setting(weights, extra);
            for (n = 0; n < PHASE_DAYS; n++) begin
               // Drain the pipe now and then; force it once mid-phase.
               hold = (mode == 1 && slot == 0 && n == 60) || ($urandom_range(0, 99) < 2);
               send_day(random_count(), hold);
            end
         end
      end
   endtask

   // Stall the result channel at the rate of the current mode.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Check each accepted result against the oldest prediction, field by field.
   always @(posedge clock) begin
      estimate_type got;
      estimate_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.r   = rsp_tdata[31:0];
         got.inc = rsp_tdata[52:32];
         got.lam = rsp_tdata[92:53];
         got.sat = rsp_tuser[0];
         if (pending_estimates.size() == 0) begin
            report_mismatch("result with no day pending", 64'(got.r), 64'd0);
         end else begin
            want = pending_estimates.pop_front();
            if (got.r !== want.r)
               report_mismatch("r_estimate", 64'(got.r), 64'(want.r));
            if (got.inc !== want.inc)
               report_mismatch("window_incidence", 64'(got.inc), 64'(want.inc));
            if (got.lam !== want.lam)
               report_mismatch("window_infectivity", 64'(got.lam), 64'(want.lam));
            if (got.sat !== want.sat)
               report_mismatch("saturated", 64'(got.sat), 64'(want.sat));
            if (rsp_tdata[95:93] !== 3'b000)
               report_mismatch("tdata padding", 64'(rsp_tdata[95:93]), 64'd0);
            if (want.sat) saturated_seen++;
            estimates_checked++;
         end
      end
   end

   // Bound the run; a hang anywhere ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  CYCLE_LIMIT, pending_estimates.size());
         $display("** renewal_window_r_estimator_top: FAILED **");
         $finish;
      end
   end

   initial begin
      // Drive reset, the request and the register inputs to a known value before the first edge.
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      days_sent     = 0;
      settings_used     = 0;
      clear_model();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_warmup_defaults();
      test_weight_extremes();
      test_saturation_edge();
      test_random_traffic();

      // Drop the last request and let the block run dry.
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_idle();

      $display("covered %0d days and %0d checked estimates (%0d clipped) over %0d settings,",
               days_sent, estimates_checked, saturated_seen, settings_used);
      $display("windows of 1 to 32 days, weights up to above one, four idling modes");
      if (error_count == 0) begin
         $display("** renewal_window_r_estimator_top: PASSED **");
      end else begin
         $display("%0d mismatches", error_count);
         $display("** renewal_window_r_estimator_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/rwre_pkg.sv
design/rwre_csr.sv
design/rwre_window_mem.sv
design/rwre_divider.sv
design/renewal_window_r_estimator_top.sv
tb/renewal_window_r_estimator_top_tb.sv
